### hdl/sca_pkg.sv
//------------------------------------------------------------------------------
// sca_pkg: shared constants and types for the sin/cos angle block.
// Holds widths, register indexes, polynomial coefficients and the pipeline
// control word.
//------------------------------------------------------------------------------
package sca_pkg;

   localparam int SampleWidth  = 12;
   localparam int UnitsWidth   = 16;
   localparam int DegWidth     = 9;
   localparam int CsrIdxWidth  = 1;
   localparam int FracBits     = 15;
   localparam int QuotBits     = 16;

   // Register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_CENTER_SIN = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CSR_CENTER_COS = 1'b1;

   localparam logic [SampleWidth-1:0] CenterSinReset = 12'd500;
   localparam logic [SampleWidth-1:0] CenterCosReset = 12'd200;

   // Polynomial coefficients, highest order first.
   localparam logic signed [17:0] Coef0 = 18'sh00470;
   localparam logic signed [17:0] Coef1 = 18'sh01029;
   localparam logic signed [17:0] Coef2 = 18'sh01F0B;
   localparam logic signed [17:0] Coef3 = 18'sh0364C;
   localparam logic signed [17:0] Coef4 = 18'sh0A2FC;

   localparam logic [UnitsWidth-1:0] HalfTurn = 16'd16384;

   // Per-word side information that rides along the pipeline.
   typedef struct packed {
      logic       zero_y;
      logic       neg_x;
      logic [2:0] oct;
   } side_type;

endpackage

### hdl/sincos_to_angle_atan2.sv
//------------------------------------------------------------------------------
// sincos_to_angle_atan2: angle of a sin/cos sample pair, fixed-point atan2.
// Octant reduction, a restoring divide one quotient bit per stage, a Horner
// polynomial one multiply per stage, and a degrees scale by 1/91.
//------------------------------------------------------------------------------
// Throughput: one word per cycle while rsp is not stalled; the whole pipeline advances together.
// The divider's sixteen quotient stages make up most of the pipeline.
// A stall on rsp holds every stage; req_stall is high while the last stage
// holds a word that cannot leave. Reset clears all valid bits and
// reloads the centers to 500 and 200.
module sincos_to_angle_atan2 #(
   parameter int SampleWidth = sca_pkg::SampleWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SampleWidth-1:0]          req_sin_sample,
   input  logic [SampleWidth-1:0]          req_cos_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sca_pkg::UnitsWidth-1:0]  rsp_angle_units,
   output logic [sca_pkg::DegWidth-1:0]    rsp_angle_degrees,
   input  logic                            csr_write,
   input  logic [sca_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [SampleWidth-1:0]          csr_data
);

   localparam int DW = SampleWidth + 2;          // signed width after reduction
   localparam int QB = sca_pkg::QuotBits;
   localparam int NS = QB + 11;                  // total stages
   localparam int P0 = QB + 1;                   // ratio stage
   localparam int PF = P0 + 5;                   // final multiply stage

   logic [SampleWidth-1:0] center_sin_ff, center_cos_ff;
   logic                   adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_sin_ff <= sca_pkg::CenterSinReset;
         center_cos_ff <= sca_pkg::CenterCosReset;
      end else if (csr_write) begin
         case (csr_index)
            sca_pkg::CSR_CENTER_SIN: center_sin_ff <= csr_data;
            sca_pkg::CSR_CENTER_COS: center_cos_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [NS-1:0] vld_ff;
   assign adv       = !(rsp_stall && vld_ff[NS-1]);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NS-1];

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], req_valid};
   end

   // Stage 0: center subtraction.
   logic signed [DW-1:0] x0_ff, y0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= DW'($signed({1'b0, req_sin_sample})) - DW'($signed({1'b0, center_sin_ff}));
         y0_ff <= DW'($signed({1'b0, req_cos_sample})) - DW'($signed({1'b0, center_cos_ff}));
      end
   end

   // Stage 1: octant reduction by three conditional swaps.
   logic signed [DW-1:0] ra, rb, rx, ry;
   sca_pkg::side_type    sd;
   always_comb begin
      ra = x0_ff; rb = y0_ff;
      sd.zero_y = (y0_ff == '0);
      sd.neg_x  = x0_ff[DW-1];
      sd.oct    = 3'd0;
      if (rb < 0) begin ra = -ra; rb = -rb; sd.oct = 3'd4; end
      if (ra <= 0) begin rx = rb; ry = -ra; sd.oct = sd.oct + 3'd2; end
      else begin rx = ra; ry = rb; end
      if (rx <= ry) begin ra = rx + ry; rb = ry - rx; sd.oct = sd.oct + 3'd1; end
      else begin ra = rx; rb = ry; end
   end

   logic [DW-1:0]     dx_ff [QB+1];
   logic [DW+QB:0]    rem_ff [QB+1];
   logic [QB-1:0]     q_ff [QB+1];
   sca_pkg::side_type sd_ff [PF+2];

   // The numerator is y scaled up by the fraction bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0]  <= ra;
         rem_ff[0] <= (DW+QB+1)'(rb) << sca_pkg::FracBits;
         q_ff[0]   <= '0;
         sd_ff[0]  <= sd;
      end
   end

   // Divider: one quotient bit of (y << 15) / x per stage, 16 bits.
   for (genvar s = 0; s < QB; s++) begin : g_div
      logic [DW+QB:0] trial;
      logic [DW+QB:0] dsh;
      assign dsh   = (DW+QB+1)'(dx_ff[s]) << (QB - 1 - s);
      assign trial = rem_ff[s] - dsh;
      always_ff @(posedge clock) begin
         if (adv) begin
            dx_ff[s+1] <= dx_ff[s];
            if (rem_ff[s] >= dsh) begin
               rem_ff[s+1] <= trial;
               q_ff[s+1]   <= q_ff[s] | QB'(1 << (QB - 1 - s));
            end else begin
               rem_ff[s+1] <= rem_ff[s];
               q_ff[s+1]   <= q_ff[s];
            end
         end
      end
   end

   for (genvar s = 1; s <= PF + 1; s++) begin : g_side
      always_ff @(posedge clock) if (adv) sd_ff[s] <= sd_ff[s-1];
   end

   // Ratio stage: y < x, so the quotient stays below 32768; square follows.
   logic signed [17:0] ratio_ff [P0:PF];
   logic signed [17:0] sq_ff [P0+1:P0+4];
   logic signed [35:0] poly_ff [P0+1:PF+3];

   logic [33:0] rsq;
   assign rsq = 34'(ratio_ff[P0]) * 34'(ratio_ff[P0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         ratio_ff[P0] <= 18'($signed({1'b0, q_ff[QB][QB-2:0]}));
         sq_ff[P0+1]   <= 18'($signed(-($signed({2'b0, rsq}) >>> 0)) >>> sca_pkg::FracBits);
         poly_ff[P0+1] <= 36'(sca_pkg::Coef0);
      end
   end

   for (genvar s = P0 + 1; s <= PF; s++) begin : g_carry
      always_ff @(posedge clock) if (adv) ratio_ff[s] <= ratio_ff[s-1];
   end
   for (genvar s = P0 + 2; s <= P0 + 4; s++) begin : g_sqc
      always_ff @(posedge clock) if (adv) sq_ff[s] <= sq_ff[s-1];
   end

   // Horner steps, one multiply per stage.
   function automatic logic signed [17:0] coef(input int k);
      case (k)
         1: coef = sca_pkg::Coef1;
         2: coef = sca_pkg::Coef2;
         3: coef = sca_pkg::Coef3;
         default: coef = sca_pkg::Coef4;
      endcase
   endfunction

   for (genvar k = 1; k <= 4; k++) begin : g_horner
      logic signed [35:0] prod;
      assign prod = 36'(sq_ff[P0+k]) * 36'($signed(poly_ff[P0+k][17:0]));
      always_ff @(posedge clock) begin
         if (adv) poly_ff[P0+k+1] <= 36'(coef(k)) + (prod >>> sca_pkg::FracBits);
      end
   end

   // Final multiply by ratio, round, add octant base.
   logic signed [35:0] pr;
   assign pr = 36'($signed(poly_ff[PF][17:0])) * 36'(ratio_ff[PF]);
   always_ff @(posedge clock) begin
      if (adv) poly_ff[PF+1] <= pr >>> sca_pkg::FracBits;
   end

   logic signed [35:0] fin;
   logic [sca_pkg::UnitsWidth-1:0] units;
   assign fin = (poly_ff[PF+1] + 36'sd4) >>> 3;
   assign units = sd_ff[PF+1].zero_y ? (sd_ff[PF+1].neg_x ? sca_pkg::HalfTurn : '0)
                : sca_pkg::UnitsWidth'({sd_ff[PF+1].oct, 12'd0}) + sca_pkg::UnitsWidth'(fin);

   always_ff @(posedge clock) begin
      if (adv) poly_ff[PF+2] <= 36'(units);
   end

   // Degrees: units * 46092 >> 22 equals units / 91 for units <= 32768.
   logic [31:0] dprod;
   assign dprod = 32'(poly_ff[PF+2][15:0]) * 32'd46092;
   always_ff @(posedge clock) begin
      if (adv) poly_ff[PF+3] <= {poly_ff[PF+2][15:0], 11'd0, dprod[30:22]};
   end

   assign rsp_angle_units   = poly_ff[PF+3][35:20];
   assign rsp_angle_degrees = poly_ff[PF+3][8:0];

endmodule

### hdl/sca_checker.sv
//------------------------------------------------------------------------------
// sca_checker: port-level checks for the angle block.
// Watches the handshakes and output ranges.
//------------------------------------------------------------------------------
module sca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_angle_units,
   input logic [8:0]  rsp_angle_degrees
);
   // Output stays within a full turn.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_units <= 16'd32768) else $error("units out of range");
   // Degrees times 91 never exceed units.
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 16'(rsp_angle_degrees) * 16'd91 <= rsp_angle_units)
      else $error("degrees mismatch");
   // Input stalls only when output is held.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("spurious stall");
   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_units))
      else $error("result dropped");
endmodule

bind sincos_to_angle_atan2 sca_checker u_sca_checker (.*);

### verif/tb_top.sv
//------------------------------------------------------------------------------
// tb_top: self-checking bench for the sin/cos angle block.
// A directed table, then random sample pairs, through several center settings.
// Each word is predicted by a bit-exact atan2 model and checked in order.
//------------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [15:0] units;
      logic [8:0]  degs;
   } angle_type;

   typedef struct {
      logic [11:0] s;
      logic [11:0] c;
      logic        known;
      logic [15:0] units;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_sin_sample = '0;
   logic [11:0] req_cos_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_angle_units;
   logic [8:0]  rsp_angle_degrees;
   logic        csr_write = 1'b0;
   logic [sca_pkg::CsrIdxWidth-1:0] csr_index = sca_pkg::CSR_CENTER_SIN;
   logic [11:0] csr_data = '0;

   logic [11:0] ctr_sin = 12'd500;
   logic [11:0] ctr_cos = 12'd200;
   angle_type   pending_angles[$];
   int          errors = 0;
   bit          hold_long = 1'b0;

   sincos_to_angle_atan2 i_dut (.*);

   always #4 clock = ~clock;

   // Floor shift for signed values.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic angle_type predict_angle(logic [11:0] s, logic [11:0] c);
      longint x, y, t, oct, ratio, sq, poly;
      angle_type a;
      x = longint'(s) - longint'(ctr_sin);
      y = longint'(c) - longint'(ctr_cos);
      oct = 0;
      if (y == 0) begin
         a.units = (x >= 0) ? 16'd0 : sca_pkg::HalfTurn;
      end else begin
         if (y < 0) begin
            x = -x; y = -y; oct += 4;
         end
         if (x <= 0) begin
            t = x; x = y; y = -t; oct += 2;
         end
         if (x <= y) begin
            t = y - x; x = x + y; y = t; oct += 1;
         end
         ratio = (x > 0) ? (y * (64'sd1 << 15)) / x : 0;
         sq = floor_shift(-(ratio * ratio), 15);
         poly = 'h470;
         poly = 'h1029 + floor_shift(sq * poly, 15);
         poly = 'h1F0B + floor_shift(sq * poly, 15);
         poly = 'h364C + floor_shift(sq * poly, 15);
         poly = 'hA2FC + floor_shift(sq * poly, 15);
         poly = floor_shift(poly * ratio, 15);
         a.units = 16'(oct * 4096 + floor_shift(poly + 4, 3));
      end
      a.degs = 9'(a.units / 91);
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Response checker.
   always @(posedge clock) begin
      angle_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected word", rsp_angle_units, -1);
         end else begin
            a = pending_angles.pop_front();
            if (rsp_angle_units !== a.units)
               report_mismatch("angle_units", rsp_angle_units, a.units);
            if (rsp_angle_degrees !== a.degs)
               report_mismatch("angle_degrees", rsp_angle_degrees, a.degs);
         end
      end
   end

   // Receiver stall pattern, plus one long hold-off on request.
   always @(posedge clock) begin
      int n;
      if (hold_long) begin
         rsp_stall <= 1'b1;
      end else begin
         n = $urandom_range(0, 9);
         rsp_stall <= (n < 3);
      end
   end

   task automatic send_word(logic [11:0] s, logic [11:0] c, logic known, logic [15:0] u);
      angle_type a;
      req_valid <= 1'b1;
      req_sin_sample <= s;
      req_cos_sample <= c;
      a = predict_angle(s, c);
      if (known && a.units !== u)
         report_mismatch("table row", a.units, u);
      pending_angles.push_back(a);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_and_write(logic [11:0] cs, logic [11:0] cc);
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= sca_pkg::CSR_CENTER_SIN;
      csr_data <= cs;
      @(posedge clock);
      csr_index <= sca_pkg::CSR_CENTER_COS;
      csr_data <= cc;
      @(posedge clock);
      csr_write <= 1'b0;
      ctr_sin = cs;
      ctr_cos = cc;
   endtask

   task automatic random_phase(int count);
      int left, burst, mode;
      logic [11:0] s, c;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && left > 0) begin
            mode = $urandom_range(0, 9);
            s = 12'($urandom);
            c = 12'($urandom);
            if (mode == 0) c = ctr_cos;
            else if (mode == 1) s = ctr_sin;
            else if (mode == 2) c = 12'(s - ctr_sin + ctr_cos);
            else if (mode == 3) c = 12'(ctr_sin - s + ctr_cos);
            send_word(s, c, 1'b0, '0);
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
   endtask

   row_type table_rows[20] = '{
      '{12'd500, 12'd200, 1'b1, 16'd0},
      '{12'd600, 12'd200, 1'b1, 16'd0},
      '{12'd400, 12'd200, 1'b1, 16'd16384},
      '{12'd0,   12'd200, 1'b1, 16'd16384},
      '{12'd4095,12'd200, 1'b1, 16'd0},
      '{12'd500, 12'd300, 1'b0, 16'd0},
      '{12'd500, 12'd100, 1'b0, 16'd0},
      '{12'd600, 12'd300, 1'b0, 16'd0},
      '{12'd400, 12'd300, 1'b0, 16'd0},
      '{12'd400, 12'd100, 1'b0, 16'd0},
      '{12'd600, 12'd100, 1'b0, 16'd0},
      '{12'd4095,12'd199, 1'b0, 16'd0},
      '{12'd4095,12'd201, 1'b0, 16'd0},
      '{12'd0,   12'd0,   1'b0, 16'd0},
      '{12'd4095,12'd4095,1'b0, 16'd0},
      '{12'd0,   12'd4095,1'b0, 16'd0},
      '{12'd4095,12'd0,   1'b0, 16'd0},
      '{12'd501, 12'd199, 1'b0, 16'd0},
      '{12'd499, 12'd201, 1'b0, 16'd0},
      '{12'd2730,12'd199, 1'b0, 16'd0}
   };

   // Stimulus sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i]) begin
         send_word(table_rows[i].s, table_rows[i].c, table_rows[i].known,
                   table_rows[i].units);
      end
      random_phase(300);
      // Long receiver hold-off while words keep being offered.
      fork
         begin
            hold_long = 1'b1;
            repeat (80) @(posedge clock);
            hold_long = 1'b0;
         end
         random_phase(100);
      join
      drain_and_write(12'd0, 12'd0);
      random_phase(250);
      drain_and_write(12'd4095, 12'd4095);
      random_phase(250);
      drain_and_write(12'd2048, 12'd1000);
      random_phase(350);
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule
